>>> hdl/ufr_pkg.sv
package ufr_pkg;

	// result kinds
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_GOOD    = 2'd1;
	localparam logic [1:0] KIND_BAD_SUM = 2'd2;
	localparam logic [1:0] KIND_TIMEOUT = 2'd3;

	// input operations
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// configuration register indexes
	localparam logic [1:0] REG_HEADER_FIRST  = 2'd0;
	localparam logic [1:0] REG_HEADER_SECOND = 2'd1;
	localparam logic [1:0] REG_TIMEOUT_LIMIT = 2'd2;

	// configuration reset values
	localparam logic [7:0] HEADER_FIRST_RST  = 8'd170;
	localparam logic [7:0] HEADER_SECOND_RST = 8'd85;
	localparam logic [7:0] TIMEOUT_LIMIT_RST = 8'd15;

	// bytes of a frame that are not payload
	localparam logic [15:0] FRAME_OVERHEAD = 16'd6;

	// one result item, as it leaves the block
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  received_sum;
		logic [7:0]  computed_sum;
		logic [15:0] payload_count;
		logic [7:0]  command;
		logic [7:0]  payload_byte;
	} res_t;

endpackage

>>> hdl/ufr_parser.sv
module ufr_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             req_op,
	input  logic [7:0]       req_byte,
	input  logic             cfg_wr_en,
	input  logic [1:0]       cfg_index,
	input  logic [7:0]       cfg_data,
	output logic             res_valid,
	output ufr_pkg::res_t    res
);

	// frame phases
	localparam logic [2:0] PH_HDR1    = 3'd0;
	localparam logic [2:0] PH_HDR2    = 3'd1;
	localparam logic [2:0] PH_LEN_HI  = 3'd2;
	localparam logic [2:0] PH_LEN_LO  = 3'd3;
	localparam logic [2:0] PH_CMD     = 3'd4;
	localparam logic [2:0] PH_PAYLOAD = 3'd5;

	logic [7:0]  header_first_q, header_second_q, timeout_limit_q;
	logic [2:0]  phase_q, phase_d;
	logic [15:0] len_q, len_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [15:0] cnt_q, cnt_d;
	logic [7:0]  tick_q, tick_d;
	logic        emit;
	logic        clear;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_first_q  <= ufr_pkg::HEADER_FIRST_RST;
			header_second_q <= ufr_pkg::HEADER_SECOND_RST;
			timeout_limit_q <= ufr_pkg::TIMEOUT_LIMIT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				ufr_pkg::REG_HEADER_FIRST:  header_first_q  <= cfg_data;
				ufr_pkg::REG_HEADER_SECOND: header_second_q <= cfg_data;
				ufr_pkg::REG_TIMEOUT_LIMIT: timeout_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// next frame state and result for one request
	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		sum_d   = sum_q;
		cmd_d   = cmd_q;
		cnt_d   = cnt_q;
		tick_d  = tick_q;
		emit    = 1'b0;
		clear   = 1'b0;
		res.kind          = ufr_pkg::KIND_PAYLOAD;
		res.payload_byte  = 8'd0;
		res.command       = cmd_q;
		res.payload_count = cnt_q;
		res.computed_sum  = sum_q;
		res.received_sum  = 8'd0;
		if (req_op == ufr_pkg::OP_TICK) begin
			// timeout runs only while a frame is open
			if (tick_q != 8'd0) begin
				if (tick_q >= timeout_limit_q) begin
					emit     = 1'b1;
					clear    = 1'b1;
					res.kind = ufr_pkg::KIND_TIMEOUT;
				end else begin
					tick_d = tick_q + 8'd1;
				end
			end
		end else begin
			unique case (phase_q)
				PH_HDR2: begin
					if (req_byte == header_second_q) phase_d = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					sum_d   = sum_q + req_byte;
					len_d   = {req_byte, 8'd0};
					phase_d = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					sum_d   = sum_q + req_byte;
					len_d   = len_q | {8'd0, req_byte};
					phase_d = PH_CMD;
				end
				PH_CMD: begin
					sum_d   = sum_q + req_byte;
					cmd_d   = req_byte;
					phase_d = PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					emit = 1'b1;
					if (len_q > ufr_pkg::FRAME_OVERHEAD) begin
						sum_d = sum_q + req_byte;
						len_d = len_q - 16'd1;
						cnt_d = cnt_q + 16'd1;
						res.payload_byte  = req_byte;
						res.payload_count = cnt_d;
						res.computed_sum  = sum_d;
					end else begin
						// checksum byte closes the frame
						clear            = 1'b1;
						res.kind         = (req_byte == sum_q) ? ufr_pkg::KIND_GOOD
						                                       : ufr_pkg::KIND_BAD_SUM;
						res.received_sum = req_byte;
					end
				end
				default: begin
					// waiting for the first header byte
					if (req_byte == header_first_q) begin
						phase_d = PH_HDR2;
						len_d   = 16'd0;
						sum_d   = 8'd0;
						cmd_d   = 8'd0;
						cnt_d   = 16'd0;
						tick_d  = 8'd1;
					end
				end
			endcase
		end
		if (clear) begin
			phase_d = PH_HDR1;
			len_d   = 16'd0;
			sum_d   = 8'd0;
			cmd_d   = 8'd0;
			cnt_d   = 16'd0;
			tick_d  = 8'd0;
		end
	end

	assign res_valid = req_valid && emit;

	// frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR1;
			len_q   <= 16'd0;
			sum_q   <= 8'd0;
			cmd_q   <= 8'd0;
			cnt_q   <= 16'd0;
			tick_q  <= 8'd0;
		end else if (req_valid) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			sum_q   <= sum_d;
			cmd_q   <= cmd_d;
			cnt_q   <= cnt_d;
			tick_q  <= tick_d;
		end
	end

	// an open frame always has its timer running
	a_timer_runs: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_HDR1 |-> tick_q != 8'd0)
		else $error("frame open with timer stopped");

	// a frame verdict or abort returns the parser to header search
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind != ufr_pkg::KIND_PAYLOAD |=> phase_q == PH_HDR1 && tick_q == 8'd0)
		else $error("frame state kept after end of frame");

	// payload only comes out of the payload phase
	a_payload_phase: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == ufr_pkg::KIND_PAYLOAD |-> phase_q == PH_PAYLOAD)
		else $error("payload result outside payload phase");

endmodule

>>> hdl/ufr_out_buf.sv
module ufr_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ufr_pkg::res_t push_data,
	output logic          room,
	output logic          out_valid,
	input  logic          out_ready,
	output ufr_pkg::res_t out_data
);

	ufr_pkg::res_t mem_q [2];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    count_q;
	logic          pop;

	assign out_valid = count_q != 2'd0;
	assign out_data  = mem_q[rd_ptr_q];
	assign room      = count_q != 2'd2;
	assign pop       = out_valid && out_ready;

	// result storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q != 2'd2)
		else $error("result pushed into full buffer");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result buffer count out of range");

endmodule

>>> hdl/uart_frame_receiver_top.sv
// channel   dir  tdata                                       tuser
// s_axis    in   [7:0] data_byte                             [0] operation
// m_axis    out  [7:0] payload_byte, [15:8] command,         [1:0] kind
//                [31:16] payload_count, [39:32] computed_sum,
//                [47:40] received_sum
// cfg       in   cfg_index selects header_first, header_second, timeout_limit
//
// one request per clock while s_tready is high; the frame state updates in the cycle of acceptance
// a result is registered into the result buffer and reaches m_axis once earlier results are taken
// a two-entry result buffer keeps s_tready high while one result waits
// s_tready drops only when two results are waiting on m_tready
// arst_n clears the frame state and result buffer and restores register defaults
module uart_frame_receiver_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // payload_byte, command, payload_count,
	                               // computed_sum, received_sum
	output logic [1:0]  m_tuser,   // [1:0] kind
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic          accept;
	logic          res_valid;
	ufr_pkg::res_t res;
	ufr_pkg::res_t out_res;

	assign accept = s_tvalid && s_tready;

	// frame parser
	ufr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (accept),
		.req_op    (s_tuser),
		.req_byte  (s_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register with skid entry
	ufr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.room      (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tuser = out_res.kind;
	assign m_tdata = {out_res.received_sum, out_res.computed_sum, out_res.payload_count,
	                  out_res.command, out_res.payload_byte};

endmodule

>>> dv/uart_frame_receiver_top_tb.sv
module uart_frame_receiver_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ufr_pkg::*;

	localparam int SETTLE_CYCLES = 4;

	// receiver phases, in the order a frame walks through them
	typedef enum logic [2:0] {
		PH_HDR1, PH_HDR2, PH_LEN_HI, PH_LEN_LO, PH_CMD, PH_BODY
	} rx_phase_e;

	// what the sender does next: a byte or tick, a register write, or a pause
	typedef enum logic [1:0] {ACT_REQ, ACT_CFG, ACT_DRAIN} act_e;

	typedef struct {
		act_e       act;
		logic       op;
		logic [7:0] data;
		logic [1:0] idx;
		bit         calm;
	} uart_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_wr_en = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	uart_req_t uart_requests[$];
	res_t      due_rx_results[$];
	bit        req_taken = 0;
	int        settle = 0;
	int        mismatches = 0;

	// register shadows, as the block should see them
	logic [7:0] hdr1_cfg = HEADER_FIRST_RST;
	logic [7:0] hdr2_cfg = HEADER_SECOND_RST;
	logic [7:0] limit_cfg = TIMEOUT_LIMIT_RST;

	// frame state of the receiver
	rx_phase_e   rx_phase = PH_HDR1;
	logic [15:0] rx_remaining = '0;
	logic [7:0]  rx_sum = '0;
	logic [7:0]  rx_cmd = '0;
	logic [15:0] rx_count = '0;
	logic [7:0]  rx_ticks = '0;

	// register values as the stimulus builder plans them
	logic [7:0] gen_hdr1 = HEADER_FIRST_RST;
	logic [7:0] gen_hdr2 = HEADER_SECOND_RST;
	logic [7:0] gen_limit = TIMEOUT_LIMIT_RST;
	int         gen_items = 0;
	int         gen_tick_room = 0;
	bit         gen_calm = 0;

	uart_frame_receiver_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------- prediction

	function automatic void clear_rx_frame();
		rx_phase = PH_HDR1;
		rx_remaining = '0;
		rx_sum = '0;
		rx_cmd = '0;
		rx_count = '0;
		rx_ticks = '0;
	endfunction

	// advance the frame state by one accepted request, queue any result it causes
	function automatic void advance_frame_rx(input logic op, input logic [7:0] b);
		res_t r;
		r = '0;
		if (op == OP_TICK) begin
			if (rx_ticks != 0) begin
				if (rx_ticks >= limit_cfg) begin
					r.kind = KIND_TIMEOUT;
					r.command = rx_cmd;
					r.payload_count = rx_count;
					r.computed_sum = rx_sum;
					due_rx_results.push_back(r);
					clear_rx_frame();
				end else begin
					rx_ticks = rx_ticks + 8'd1;
				end
			end
		end else begin
			case (rx_phase)
				PH_HDR2: begin
					if (b == hdr2_cfg)
						rx_phase = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					rx_sum = rx_sum + b;
					rx_remaining = {b, 8'h00};
					rx_phase = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					rx_sum = rx_sum + b;
					rx_remaining[7:0] = b;
					rx_phase = PH_CMD;
				end
				PH_CMD: begin
					rx_sum = rx_sum + b;
					rx_cmd = b;
					rx_phase = PH_BODY;
				end
				PH_BODY: begin
					if (rx_remaining > FRAME_OVERHEAD) begin
						// payload byte goes straight out
						rx_sum = rx_sum + b;
						rx_remaining = rx_remaining - 16'd1;
						rx_count = rx_count + 16'd1;
						r.kind = KIND_PAYLOAD;
						r.payload_byte = b;
						r.command = rx_cmd;
						r.payload_count = rx_count;
						r.computed_sum = rx_sum;
						due_rx_results.push_back(r);
					end else begin
						// checksum byte closes the frame
						r.kind = (b == rx_sum) ? KIND_GOOD : KIND_BAD_SUM;
						r.command = rx_cmd;
						r.payload_count = rx_count;
						r.computed_sum = rx_sum;
						r.received_sum = b;
						due_rx_results.push_back(r);
						clear_rx_frame();
					end
				end
				default: begin
					if (b == hdr1_cfg) begin
						clear_rx_frame();
						rx_phase = PH_HDR2;
						rx_ticks = 8'd1;
					end
				end
			endcase
		end
	endfunction

	function automatic void check_field(input string field, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected 0x%0h actual 0x%0h", $time, field, want, got);
			mismatches++;
		end
	endfunction

	// ---------------------------------------------------------------- monitor

	always @(posedge clk) begin : observe
		res_t got;
		res_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = {m_tuser, m_tdata};
				if (due_rx_results.size() == 0) begin
					$display("%0t ns: unexpected result, expected none actual kind %0d data 0x%0h",
						$time, got.kind, m_tdata);
					mismatches++;
				end else begin
					want = due_rx_results.pop_front();
					check_field("kind", want.kind, got.kind);
					check_field("payload_byte", want.payload_byte, got.payload_byte);
					check_field("command", want.command, got.command);
					check_field("payload_count", want.payload_count, got.payload_count);
					check_field("computed_sum", want.computed_sum, got.computed_sum);
					check_field("received_sum", want.received_sum, got.received_sum);
				end
			end
			if (s_tvalid && s_tready) begin
				advance_frame_rx(s_tuser, s_tdata);
				req_taken = 1;
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_HEADER_FIRST:  hdr1_cfg = cfg_data;
					REG_HEADER_SECOND: hdr2_cfg = cfg_data;
					REG_TIMEOUT_LIMIT: limit_cfg = cfg_data;
					default: ;
				endcase
			end
		end
	end

	// ---------------------------------------------------------------- driver

	always @(negedge clk) begin : drive
		bit taken;
		bit hold;
		bit nv;
		bit wr;
		bit calm;
		if (arst_n) begin
			taken = req_taken;
			req_taken = 0;
			if (taken)
				void'(uart_requests.pop_front());
			hold = s_tvalid && !taken;
			nv = hold;
			wr = 0;
			calm = (uart_requests.size() != 0) && uart_requests[0].calm;
			if (!hold && uart_requests.size() != 0) begin
				if (uart_requests[0].act == ACT_REQ) begin
					settle = 0;
					if (calm || $urandom_range(99) >= 16) begin
						nv = 1;
						s_tdata <= uart_requests[0].data;
						s_tuser <= uart_requests[0].op;
					end
				end else if (due_rx_results.size() != 0) begin
					settle = 0;
				end else if (settle < SETTLE_CYCLES) begin
					settle++;
				end else begin
					// block is idle: write the register or just resume
					settle = 0;
					if (uart_requests[0].act == ACT_CFG) begin
						wr = 1;
						cfg_index <= uart_requests[0].idx;
						cfg_data <= uart_requests[0].data;
					end
					void'(uart_requests.pop_front());
				end
			end
			s_tvalid <= nv;
			cfg_wr_en <= wr;
			m_tready <= calm || $urandom_range(99) >= 16;
		end
	end

	// ---------------------------------------------------------------- stimulus builder

	function automatic void add_req(input logic op, input logic [7:0] b, input bit counted = 1);
		uart_req_t e;
		e.act = ACT_REQ;
		e.op = op;
		e.data = b;
		e.idx = '0;
		e.calm = gen_calm;
		uart_requests.push_back(e);
		if (counted)
			gen_items++;
	endfunction

	function automatic void add_pause(input act_e act, input logic [1:0] idx,
		input logic [7:0] val);
		uart_req_t e;
		e.act = act;
		e.op = OP_BYTE;
		e.data = val;
		e.idx = idx;
		e.calm = gen_calm;
		uart_requests.push_back(e);
		if (act == ACT_CFG) begin
			case (idx)
				REG_HEADER_FIRST:  gen_hdr1 = val;
				REG_HEADER_SECOND: gen_hdr2 = val;
				REG_TIMEOUT_LIMIT: gen_limit = val;
				default: ;
			endcase
		end
	endfunction

	// frame byte, sometimes preceded by a tick while the tick budget lasts
	function automatic void add_frame_byte(input logic [7:0] b);
		if (gen_tick_room > 0 && $urandom_range(7) == 0) begin
			add_req(OP_TICK, 8'($urandom));
			gen_tick_room--;
		end
		add_req(OP_BYTE, b);
	endfunction

	// one frame; stops early, without checksum, when body_max cuts the payload short
	function automatic void add_frame(input logic [15:0] len, input logic [7:0] cmd,
		input int body_max, input bit bad_sum, input int strays);
		int n_body;
		logic [7:0] sum;
		logic [7:0] b;
		n_body = (len > FRAME_OVERHEAD) ? int'(len - FRAME_OVERHEAD) : 0;
		add_req(OP_BYTE, gen_hdr1);
		repeat (strays)
			add_frame_byte(gen_hdr2 ^ 8'($urandom_range(1, 255)));
		add_frame_byte(gen_hdr2);
		sum = len[15:8] + len[7:0] + cmd;
		add_frame_byte(len[15:8]);
		add_frame_byte(len[7:0]);
		add_frame_byte(cmd);
		for (int i = 0; i < n_body && i < body_max; i++) begin
			b = 8'($urandom);
			sum = sum + b;
			add_frame_byte(b);
		end
		if (n_body <= body_max)
			add_frame_byte(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
	endfunction

	// enough ticks to abort any open frame; the extra ones are ignored
	function automatic void add_timeout_ticks();
		repeat (int'(gen_limit) + 1)
			add_req(OP_TICK, 8'($urandom), 0);
	endfunction

	function automatic logic [7:0] pick_header();
		case ($urandom_range(5))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_limit();
		case ($urandom_range(9))
			0: return 8'd1;
			1: return 8'd255;
			2: return 8'($urandom_range(1, 255));
			default: return 8'($urandom_range(2, 30));
		endcase
	endfunction

	function automatic void build_requests();
		int sel;
		int n;
		logic [15:0] len;
		logic [7:0] b;

		// directed: bytes that are not a header, tick with the timer stopped
		add_req(OP_BYTE, 8'h00);
		add_req(OP_BYTE, 8'hFF);
		add_req(OP_TICK, 8'hFF);
		// zero length with a stray byte before the second header byte, bad checksum
		add_frame(16'h0000, 8'h00, 0, 1, 1);
		// largest length, one payload byte, then the tick that aborts at limit one
		add_pause(ACT_CFG, REG_TIMEOUT_LIMIT, 8'd1);
		add_frame(16'hFFFF, 8'hFF, 1, 0, 0);
		add_req(OP_TICK, 8'h00);
		// limit lowered below the running count mid frame
		add_pause(ACT_CFG, REG_TIMEOUT_LIMIT, 8'd255);
		add_frame(16'h0007, 8'h80, 0, 0, 0);
		add_req(OP_TICK, 8'h55);
		add_req(OP_TICK, 8'hAA);
		add_pause(ACT_CFG, REG_TIMEOUT_LIMIT, 8'd2);
		add_req(OP_TICK, 8'h00);
		// extreme header values, overhead-only length, good checksum
		add_pause(ACT_CFG, REG_HEADER_FIRST, 8'h00);
		add_pause(ACT_CFG, REG_HEADER_SECOND, 8'hFF);
		add_pause(ACT_CFG, REG_TIMEOUT_LIMIT, TIMEOUT_LIMIT_RST);
		add_frame(16'h0006, 8'h7F, 0, 0, 0);

		// random: mostly well-formed frames, some noise, broken frames and new settings
		while (gen_items < 700) begin
			gen_calm = (gen_items >= 250 && gen_items < 400);
			if ($urandom_range(14) == 0) begin
				case ($urandom_range(2))
					0: add_pause(ACT_CFG, REG_HEADER_FIRST, pick_header());
					1: add_pause(ACT_CFG, REG_HEADER_SECOND, pick_header());
					default: add_pause(ACT_CFG, REG_TIMEOUT_LIMIT, pick_limit());
				endcase
			end
			sel = $urandom_range(99);
			if (sel < 90 && sel >= 80)
				add_pause(ACT_DRAIN, '0, '0);
			if (sel < 65 || sel >= 80) begin
				len = ($urandom_range(4) == 0) ? 16'($urandom_range(0, 6))
				                               : 16'(6 + $urandom_range(0, 10));
				gen_tick_room = int'(gen_limit) - 1;
				add_frame(len, 8'($urandom), 16, $urandom_range(4) == 0,
					($urandom_range(5) == 0) ? $urandom_range(1, 2) : 0);
			end else if (sel < 75) begin
				// noise while waiting for a frame
				n = $urandom_range(1, 4);
				repeat (n) begin
					b = 8'($urandom);
					if (b == gen_hdr1)
						b = b ^ 8'h01;
					if ($urandom_range(1) == 0)
						add_req(OP_TICK, b);
					else
						add_req(OP_BYTE, b);
				end
			end else if (gen_limit <= 40) begin
				// frame cut short and left to time out
				len = 16'(6 + $urandom_range(1, 12));
				gen_tick_room = int'(gen_limit) - 1;
				add_frame(len, 8'($urandom), $urandom_range(0, int'(len) - 7), 0, 0);
				add_timeout_ticks();
			end else begin
				gen_tick_room = 0;
				add_frame(16'(6 + $urandom_range(0, 4)), 8'($urandom), 16, 0, 0);
			end
		end
		gen_calm = 0;
	endfunction

	// ---------------------------------------------------------------- run control

	initial begin
		build_requests();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (uart_requests.size() != 0 || s_tvalid)
			@(posedge clk);
		while (due_rx_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// run limit, far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("%0t ns: timeout with %0d requests and %0d results outstanding", $time,
			uart_requests.size(), due_rx_results.size());
		$display("Regression FAIL");
		$finish;
	end

endmodule
